// ===== rtl/tld_pkg.sv =====
// Shared types and constants of the TIFF LZW decoder.
package tld_pkg;

	localparam int unsigned DICT_ENTRIES  = 4096;
	localparam int unsigned MAX_CODE_BITS = 12;
	localparam int unsigned ADDR_W        = $clog2(DICT_ENTRIES);
	localparam int unsigned STACK_DEPTH   = 4096;
	localparam int unsigned STACK_AW      = $clog2(STACK_DEPTH);

	localparam logic [11:0] CLEAR_CODE = 12'd256;
	localparam logic [11:0] END_CODE   = 12'd257;
	localparam logic [12:0] FIRST_FREE = 13'd258;
	localparam logic [3:0]  MIN_WIDTH  = 4'd9;

	localparam logic [1:0] CMD_PUSH    = 2'd0;
	localparam logic [1:0] CMD_PULL    = 2'd1;
	localparam logic [1:0] CMD_END     = 2'd2;
	localparam logic [1:0] CMD_RESTART = 2'd3;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_NEED_IN  = 3'd1;
	localparam logic [2:0] ST_FINISHED = 3'd2;
	localparam logic [2:0] ST_BAD_CODE = 3'd3;
	localparam logic [2:0] ST_MISMATCH = 3'd4;

	typedef struct packed {
		logic [11:0] prefix;
		logic [7:0]  suffix;
		logic [7:0]  first;
	} dict_ent_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		dict_ent_t         ent;
	} dict_wr_t;

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_DECODE = 6'b000010,
		S_FPREV  = 6'b000100,
		S_WALK   = 6'b001000,
		S_POP    = 6'b010000,
		S_EMIT   = 6'b100000
	} fsm_t;

endpackage

// ===== rtl/tld_codeunit.sv =====
// Shift unit that takes the next code MSB-first out of the bit buffer.
module tld_codeunit (
	input  logic [23:0] bits,
	input  logic [4:0]  bit_cnt,
	input  logic [3:0]  width,
	output logic        enough,
	output logic [11:0] code,
	output logic [4:0]  rem_cnt,
	output logic [23:0] rem_bits
);

	logic [4:0]  sh;
	logic [23:0] shifted;
	logic [11:0] mask;

	always_comb begin
		enough   = bit_cnt >= {1'b0, width};
		sh       = bit_cnt - {1'b0, width};
		shifted  = bits >> sh;
		mask     = (12'd1 << width) - 12'd1;
		code     = shifted[11:0] & mask;
		rem_cnt  = sh;
		rem_bits = bits & ((24'd1 << sh) - 24'd1);
	end

endmodule

// ===== rtl/tld_dict.sv =====
// Dictionary memory: prefix, suffix and first-byte tables, registered read.
module tld_dict (
	input  logic                           clk,
	input  tld_pkg::dict_wr_t              wr,
	input  logic [tld_pkg::ADDR_W-1:0]     rd_addr,
	output tld_pkg::dict_ent_t             rd_data
);

	logic [11:0] prefix_mem [tld_pkg::DICT_ENTRIES];
	logic [7:0]  suffix_mem [tld_pkg::DICT_ENTRIES];
	logic [7:0]  first_mem  [tld_pkg::DICT_ENTRIES];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			prefix_mem[wr.addr] <= wr.ent.prefix;
			suffix_mem[wr.addr] <= wr.ent.suffix;
			first_mem[wr.addr]  <= wr.ent.first;
		end
		rd_data.prefix <= prefix_mem[rd_addr];
		rd_data.suffix <= suffix_mem[rd_addr];
		rd_data.first  <= first_mem[rd_addr];
	end

endmodule

// ===== rtl/tld_stack.sv =====
// String stack memory: one write and one registered read per cycle.
module tld_stack (
	input  logic                          clk,
	input  logic                          we,
	input  logic [tld_pkg::STACK_AW-1:0]  waddr,
	input  logic [7:0]                    wdata,
	input  logic [tld_pkg::STACK_AW-1:0]  raddr,
	output logic [7:0]                    rdata
);

	logic [7:0] mem [tld_pkg::STACK_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/tiff_lzw_decoder.sv =====
// Top level of the TIFF LZW decoder: command sequencer, state and ports.
//
// TIFF-style LZW decoder with 9 to 12 bit codes and early width change. Each
// input word carries a command (push a compressed byte, pull a decoded byte,
// end of input, restart) and yields exactly one output word. Push, end and
// restart are handled in the sequencer's idle state. A pull served from the
// string stack steps through accept, stack read and emit. A pull that finds
// the stack empty decodes codes first: it takes each code from the bit buffer
// (clear codes loop here), looks up the first byte of the previous code when
// there is one, and then walks the prefix chain through the dictionary memory
// byte by byte, its single read port setting the pace; the stack read and
// emit steps follow.
// The block takes no new word while a command is in progress or while its
// result word waits to be taken. expected_length lies at APB address 0; a value
// of 0 turns the length limit and check off. After a bad code or length error
// the receiver should drop the bytes already delivered for the strip.
module tiff_lzw_decoder (
	input  logic        clk,
	input  logic        arst_n,
	// APB configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// command words
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // [1:0] cmd, [9:2] data_byte, rest zero
	// result words
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // [7:0] out_byte, [8] out_valid,
	                              // [9] push_accepted, [12:10] status
	output logic        m_tlast
);

	// configuration
	logic [23:0] exp_len_q;

	// decoder state
	tld_pkg::fsm_t state_q;
	logic [12:0] sc_q;
	logic [23:0] buf_q;
	logic [4:0]  cnt_q;
	logic [3:0]  width_q;
	logic [12:0] nc_q;
	logic [11:0] prev_q;
	logic        pv_q;
	logic [23:0] emitted_q;
	logic        ended_q;
	logic        fin_q;
	logic        err_q;
	logic        mis_q;

	// per-code work registers
	logic [11:0] code_q;
	logic        kwk_q;
	logic [11:0] walk_q;
	logic        first_step_q;
	logic [7:0]  first_q;
	logic [7:0]  fbp_q;

	// result word
	logic        m_tvalid_q;
	logic [7:0]  obyte_q;
	logic        ovalid_q;
	logic        pacc_q;
	logic [2:0]  status_q;
	logic        last_q;

	// input fields
	logic [1:0]  cmd;
	logic [7:0]  data_byte;
	assign cmd       = s_tdata[1:0];
	assign data_byte = s_tdata[9:2];

	// APB
	logic cfg_wr;
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & ~paddr[2];
	assign prdata = paddr[2] ? 32'd0 : {8'd0, exp_len_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_len_q <= '0;
		end else if (cfg_wr) begin
			exp_len_q <= pwdata[23:0];
		end
	end

	// handshake
	logic in_acc;
	assign s_tready = (state_q == tld_pkg::S_IDLE) & ~m_tvalid_q;
	assign in_acc   = s_tvalid & s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {3'd0, status_q, pacc_q, ovalid_q, obyte_q};
	assign m_tlast  = last_q;

	// code extraction
	logic        enough;
	logic [11:0] code;
	logic [4:0]  rem_cnt;
	logic [23:0] rem_bits;

	tld_codeunit u_code (
		.bits     (buf_q),
		.bit_cnt  (cnt_q),
		.width    (width_q),
		.enough   (enough),
		.code     (code),
		.rem_cnt  (rem_cnt),
		.rem_bits (rem_bits)
	);

	// dictionary
	tld_pkg::dict_wr_t  dwr;
	logic [11:0]        d_raddr;
	tld_pkg::dict_ent_t drd;

	tld_dict u_dict (
		.clk     (clk),
		.wr      (dwr),
		.rd_addr (d_raddr),
		.rd_data (drd)
	);

	// string stack
	logic        stk_we;
	logic [7:0]  stk_wdata;
	logic [11:0] stk_raddr;
	logic [7:0]  stk_rdata;

	tld_stack u_stack (
		.clk   (clk),
		.we    (stk_we),
		.waddr (sc_q[11:0]),
		.wdata (stk_wdata),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	// decode of the current code
	logic        is_lit;
	logic        is_known;
	logic        is_kwk;
	logic [11:0] walk_start;
	logic        walk_lit;
	logic [7:0]  fbp_w;
	logic [7:0]  first_w;
	logic        add_entry;
	logic [12:0] nc_inc;
	logic [12:0] grow_at;
	logic        end_err;
	logic        pre_fin;
	logic [23:0] emitted_inc;
	logic [2:0]  cur_status;

	always_comb begin
		is_lit      = code < 12'd256;
		is_known    = ({1'b0, code} >= tld_pkg::FIRST_FREE) & ({1'b0, code} < nc_q);
		is_kwk      = ({1'b0, code} == nc_q) & pv_q;
		walk_start  = is_kwk ? prev_q : code;
		walk_lit    = {1'b0, walk_q} < tld_pkg::FIRST_FREE;
		fbp_w       = (prev_q < 12'd256) ? prev_q[7:0] : drd.first;
		if (kwk_q) begin
			first_w = fbp_q;
		end else if (first_step_q) begin
			first_w = walk_lit ? walk_q[7:0] : drd.first;
		end else begin
			first_w = first_q;
		end
		add_entry   = pv_q & (nc_q < 13'(tld_pkg::DICT_ENTRIES));
		nc_inc      = nc_q + 13'd1;
		grow_at     = (13'd1 << width_q) - 13'd1;
		end_err     = (exp_len_q != 24'd0) & (emitted_q != exp_len_q);
		pre_fin     = ~err_q & ~fin_q & (exp_len_q != 24'd0) & (emitted_q >= exp_len_q);
		emitted_inc = emitted_q + 24'd1;
		if (err_q) begin
			cur_status = mis_q ? tld_pkg::ST_MISMATCH : tld_pkg::ST_BAD_CODE;
		end else if (fin_q) begin
			cur_status = tld_pkg::ST_FINISHED;
		end else begin
			cur_status = tld_pkg::ST_OK;
		end
	end

	// memory port control
	always_comb begin
		d_raddr   = walk_q;
		dwr       = '0;
		stk_we    = 1'b0;
		stk_wdata = '0;
		stk_raddr = 12'(sc_q - 13'd1);
		case (state_q)
			tld_pkg::S_DECODE: begin
				d_raddr = pv_q ? prev_q : walk_start;
			end
			tld_pkg::S_FPREV: begin
				// the KwKwK string ends in its own first byte
				stk_we    = kwk_q;
				stk_wdata = fbp_w;
			end
			tld_pkg::S_WALK: begin
				stk_we = 1'b1;
				if (walk_lit) begin
					stk_wdata      = walk_q[7:0];
					dwr.en         = add_entry;
					dwr.addr       = nc_q[11:0];
					dwr.ent.prefix = prev_q;
					dwr.ent.suffix = first_w;
					dwr.ent.first  = fbp_q;
				end else begin
					stk_wdata = drd.suffix;
					d_raddr   = drd.prefix;
				end
			end
			default: begin
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= tld_pkg::S_IDLE;
			sc_q         <= '0;
			buf_q        <= '0;
			cnt_q        <= '0;
			width_q      <= tld_pkg::MIN_WIDTH;
			nc_q         <= tld_pkg::FIRST_FREE;
			prev_q       <= '0;
			pv_q         <= 1'b0;
			emitted_q    <= '0;
			ended_q      <= 1'b0;
			fin_q        <= 1'b0;
			err_q        <= 1'b0;
			mis_q        <= 1'b0;
			m_tvalid_q   <= 1'b0;
			kwk_q        <= 1'b0;
			first_step_q <= 1'b0;
			code_q       <= '0;
			walk_q       <= '0;
			first_q      <= '0;
			fbp_q        <= '0;
			obyte_q      <= '0;
			ovalid_q     <= 1'b0;
			pacc_q       <= 1'b0;
			status_q     <= tld_pkg::ST_OK;
			last_q       <= 1'b0;
		end else begin
			if (m_tvalid_q & m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				tld_pkg::S_IDLE: begin
					if (in_acc) begin
						obyte_q  <= '0;
						ovalid_q <= 1'b0;
						pacc_q   <= 1'b0;
						last_q   <= 1'b0;
						status_q <= cur_status;
						case (cmd)
							tld_pkg::CMD_RESTART: begin
								sc_q       <= '0;
								buf_q      <= '0;
								cnt_q      <= '0;
								width_q    <= tld_pkg::MIN_WIDTH;
								nc_q       <= tld_pkg::FIRST_FREE;
								prev_q     <= '0;
								pv_q       <= 1'b0;
								emitted_q  <= '0;
								ended_q    <= 1'b0;
								fin_q      <= 1'b0;
								err_q      <= 1'b0;
								mis_q      <= 1'b0;
								status_q   <= tld_pkg::ST_OK;
								m_tvalid_q <= 1'b1;
							end
							tld_pkg::CMD_END: begin
								ended_q    <= 1'b1;
								m_tvalid_q <= 1'b1;
							end
							tld_pkg::CMD_PUSH: begin
								// drop bytes once the strip is over
								if (err_q | fin_q | ended_q) begin
									pacc_q <= 1'b1;
								end else if (cnt_q <= 5'd16) begin
									buf_q  <= {buf_q[15:0], data_byte};
									cnt_q  <= cnt_q + 5'd8;
									pacc_q <= 1'b1;
								end
								m_tvalid_q <= 1'b1;
							end
							default: begin
								// pull
								if (pre_fin) begin
									fin_q      <= 1'b1;
									sc_q       <= '0;
									status_q   <= tld_pkg::ST_FINISHED;
									m_tvalid_q <= 1'b1;
								end else if (err_q | fin_q) begin
									m_tvalid_q <= 1'b1;
								end else if (sc_q != 13'd0) begin
									state_q <= tld_pkg::S_POP;
								end else begin
									state_q <= tld_pkg::S_DECODE;
								end
							end
						endcase
					end
				end
				tld_pkg::S_DECODE: begin
					if (!enough) begin
						if (ended_q) begin
							if (end_err) begin
								err_q    <= 1'b1;
								mis_q    <= 1'b1;
								status_q <= tld_pkg::ST_MISMATCH;
							end else begin
								fin_q    <= 1'b1;
								status_q <= tld_pkg::ST_FINISHED;
							end
						end else begin
							status_q <= tld_pkg::ST_NEED_IN;
						end
						m_tvalid_q <= 1'b1;
						state_q    <= tld_pkg::S_IDLE;
					end else begin
						cnt_q <= rem_cnt;
						buf_q <= rem_bits;
						if (code == tld_pkg::CLEAR_CODE) begin
							width_q <= tld_pkg::MIN_WIDTH;
							nc_q    <= tld_pkg::FIRST_FREE;
							pv_q    <= 1'b0;
						end else if (code == tld_pkg::END_CODE) begin
							if (end_err) begin
								err_q    <= 1'b1;
								mis_q    <= 1'b1;
								status_q <= tld_pkg::ST_MISMATCH;
							end else begin
								fin_q    <= 1'b1;
								status_q <= tld_pkg::ST_FINISHED;
							end
							m_tvalid_q <= 1'b1;
							state_q    <= tld_pkg::S_IDLE;
						end else if (is_lit | is_known | is_kwk) begin
							code_q       <= code;
							kwk_q        <= is_kwk;
							walk_q       <= walk_start;
							first_step_q <= 1'b1;
							state_q      <= pv_q ? tld_pkg::S_FPREV : tld_pkg::S_WALK;
						end else begin
							err_q      <= 1'b1;
							status_q   <= tld_pkg::ST_BAD_CODE;
							m_tvalid_q <= 1'b1;
							state_q    <= tld_pkg::S_IDLE;
						end
					end
				end
				tld_pkg::S_FPREV: begin
					fbp_q <= fbp_w;
					if (kwk_q) begin
						sc_q <= sc_q + 13'd1;
					end
					state_q <= tld_pkg::S_WALK;
				end
				tld_pkg::S_WALK: begin
					first_step_q <= 1'b0;
					first_q      <= first_w;
					sc_q         <= sc_q + 13'd1;
					if (walk_lit) begin
						// chain done: add the new entry, advance the width early
						if (add_entry) begin
							nc_q <= nc_inc;
							if ((nc_inc == grow_at) && (width_q < 4'(tld_pkg::MAX_CODE_BITS))) begin
								width_q <= width_q + 4'd1;
							end
						end
						prev_q  <= code_q;
						pv_q    <= 1'b1;
						state_q <= tld_pkg::S_POP;
					end else begin
						walk_q <= drd.prefix;
					end
				end
				tld_pkg::S_POP: begin
					sc_q    <= sc_q - 13'd1;
					state_q <= tld_pkg::S_EMIT;
				end
				tld_pkg::S_EMIT: begin
					obyte_q   <= stk_rdata;
					ovalid_q  <= 1'b1;
					status_q  <= tld_pkg::ST_OK;
					emitted_q <= emitted_inc;
					if ((exp_len_q != 24'd0) && (emitted_inc >= exp_len_q)) begin
						last_q <= 1'b1;
						fin_q  <= 1'b1;
						sc_q   <= '0;
					end
					m_tvalid_q <= 1'b1;
					state_q    <= tld_pkg::S_IDLE;
				end
				default: begin
					state_q <= tld_pkg::S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== tb/tb_tiff_lzw_decoder.sv =====
// Self-checking testbench of the TIFF LZW decoder: directed table, then random code streams and command noise.
module tb_tiff_lzw_decoder;
	timeunit 1ns;
	timeprecision 1ps;

	// one result word as the block returns it
	typedef struct packed {
		logic [7:0] ob;
		logic       ov;
		logic       pa;
		logic [2:0] st;
		logic       lst;
	} result_t;

	// one row of the directed table; fixed rows carry their own expected word
	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] data;
		logic       fixed;
		result_t    want;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic        m_tlast;

	tiff_lzw_decoder uut (.*);

	always #10 clk = ~clk;

	// ---------------------------------------------------------------
	// Decoder state as the predictor keeps it
	// ---------------------------------------------------------------
	logic [23:0]      len_limit;
	logic [11:0]      pfx_mem [tld_pkg::DICT_ENTRIES];
	logic [7:0]       sfx_mem [tld_pkg::DICT_ENTRIES];
	logic [7:0]       head_mem [tld_pkg::DICT_ENTRIES];
	logic [7:0]       str_stk [tld_pkg::STACK_DEPTH];
	int unsigned      stk_cnt;
	int unsigned      bbuf, bcnt, cwidth, free_code;
	logic [11:0]      prev_code;
	logic             prev_ok, in_done, done_f, err_f, mism_f;
	logic [23:0]      emitted;

	result_t          pending_words [$];
	int               fail_cnt = 0;
	int               words_sent = 0;
	bit               quiet = 1'b0;
	bit               hold_sink = 1'b0;
	int unsigned      sink_gap = 0;

	function void clear_decoder();
		stk_cnt = 0; bbuf = 0; bcnt = 0; cwidth = 9; free_code = tld_pkg::FIRST_FREE;
		prev_code = '0; prev_ok = 0; emitted = '0;
		in_done = 0; done_f = 0; err_f = 0; mism_f = 0;
	endfunction

	function logic [2:0] cond_status();
		if (err_f) return mism_f ? tld_pkg::ST_MISMATCH : tld_pkg::ST_BAD_CODE;
		if (done_f) return tld_pkg::ST_FINISHED;
		return tld_pkg::ST_OK;
	endfunction

	function void stk_push(logic [7:0] b);
		if (stk_cnt < tld_pkg::STACK_DEPTH) begin
			str_stk[stk_cnt] = b;
			stk_cnt++;
		end
	endfunction

	// push the string of a known code, last byte first
	function void spill(int unsigned c);
		int unsigned guard;
		guard = 0;
		c &= 12'hFFF;
		while (c >= tld_pkg::FIRST_FREE && guard < tld_pkg::STACK_DEPTH) begin
			stk_push(sfx_mem[c]);
			c = pfx_mem[c];
			guard++;
		end
		stk_push(c[7:0]);
	endfunction

	function logic [7:0] lead_byte(int unsigned c);
		c &= 12'hFFF;
		return (c < 256) ? c[7:0] : head_mem[c];
	endfunction

	function void close_strip();
		if (len_limit != 0 && emitted != len_limit) begin
			err_f = 1; mism_f = 1;
		end else
			done_f = 1;
	endfunction

	// take codes until the stack holds bytes or no code can be had
	function logic [2:0] decode_next();
		int unsigned code;
		logic [7:0]  fb;
		forever begin
			if (bcnt < cwidth) begin
				if (in_done) begin
					close_strip();
					return cond_status();
				end
				return tld_pkg::ST_NEED_IN;
			end
			code = (bbuf >> (bcnt - cwidth)) & ((1 << cwidth) - 1);
			bcnt -= cwidth;
			bbuf &= (1 << bcnt) - 1;
			if (code == tld_pkg::CLEAR_CODE) begin
				cwidth = 9; free_code = tld_pkg::FIRST_FREE; prev_ok = 0;
				continue;
			end
			if (code == tld_pkg::END_CODE) begin
				close_strip();
				return cond_status();
			end
			if (code < 256 || (code >= tld_pkg::FIRST_FREE && code < free_code)) begin
				fb = lead_byte(code);
				spill(code);
			end else if (code == free_code && prev_ok) begin
				fb = lead_byte(prev_code);
				stk_push(fb);
				spill(prev_code);
			end else begin
				err_f = 1;
				return tld_pkg::ST_BAD_CODE;
			end
			if (prev_ok && free_code < tld_pkg::DICT_ENTRIES) begin
				pfx_mem[free_code] = prev_code;
				sfx_mem[free_code] = fb;
				head_mem[free_code] = lead_byte(prev_code);
				free_code++;
				if (free_code == (1 << cwidth) - 1 && cwidth < tld_pkg::MAX_CODE_BITS)
					cwidth++;
			end
			prev_code = code[11:0];
			prev_ok = 1;
			return tld_pkg::ST_OK;
		end
	endfunction

	function result_t apply_word(logic [1:0] cmd, logic [7:0] data);
		result_t     r;
		logic [2:0]  st;
		r = '0;
		case (cmd)
			tld_pkg::CMD_RESTART: clear_decoder();
			tld_pkg::CMD_END: begin
				in_done = 1;
				r.st = cond_status();
			end
			tld_pkg::CMD_PUSH: begin
				if (err_f || done_f || in_done) r.pa = 1;
				else if (bcnt <= 16) begin
					bbuf = ((bbuf << 8) | data) & 24'hFFFFFF;
					bcnt += 8;
					r.pa = 1;
				end
				r.st = cond_status();
			end
			default: begin
				if (!err_f && !done_f && len_limit != 0 && emitted >= len_limit) begin
					done_f = 1; stk_cnt = 0;
				end
				if (err_f || done_f) begin
					r.st = cond_status();
					return r;
				end
				if (stk_cnt == 0) begin
					st = decode_next();
					if (stk_cnt == 0) begin
						r.st = st;
						return r;
					end
				end
				stk_cnt--;
				r.ob = str_stk[stk_cnt % tld_pkg::STACK_DEPTH];
				r.ov = 1;
				emitted++;
				if (len_limit != 0 && emitted >= len_limit) begin
					r.lst = 1; done_f = 1; stk_cnt = 0;
				end
			end
		endcase
		return r;
	endfunction

	// ---------------------------------------------------------------
	// Drivers
	// ---------------------------------------------------------------
	function int unsigned pick_gap();
		int unsigned r;
		if (quiet) return 0;
		r = $urandom_range(99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// offer one word, wait for the handshake, then predict its result
	task automatic send(input logic [1:0] cmd, input logic [7:0] data, input bit fixed,
			input result_t want, output result_t got);
		int unsigned gap;
		s_tvalid <= 1'b1;
		s_tdata  <= {6'd0, data, cmd};
		do @(posedge clk); while (!s_tready);
		got = apply_word(cmd, data);
		pending_words = {pending_words, fixed ? want : got};
		words_sent++;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic put(input logic [1:0] cmd, input logic [7:0] data, output result_t got);
		send(cmd, data, 1'b0, '0, got);
	endtask

	// hold until every expected word is back, then let the block settle
	task automatic drain();
		s_tvalid <= 1'b0;
		wait (pending_words.size() == 0);
		repeat (10) @(posedge clk);
	endtask

	task automatic reg_write(input logic [23:0] v);
		@(posedge clk);
		psel <= 1'b1; pwrite <= 1'b1; paddr <= '0; pwdata <= {8'd0, v}; penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		len_limit = v;
	endtask

	// ---------------------------------------------------------------
	// Code stream generator: mostly well-formed, sometimes a bad code
	// ---------------------------------------------------------------
	task automatic make_stream(input int ncodes, input bit literal_heavy,
			output logic [7:0] bytes [$], output bit end_code);
		int unsigned nc, w, code, r;
		bit          pv;
		logic [63:0] acc;
		int          nb;
		bytes = {}; nc = tld_pkg::FIRST_FREE; w = 9; pv = 0; acc = '0; nb = 0; end_code = 0;
		for (int k = 0; k < ncodes; k++) begin
			r = $urandom_range(99);
			if (!literal_heavy && r < 5) begin
				code = tld_pkg::CLEAR_CODE; nc = tld_pkg::FIRST_FREE; w = 9; pv = 0;
			end else if (!literal_heavy && r < 8 && nc + 1 < (1 << w)) begin
				// beyond the next free code: the decoder must flag it
				code = $urandom_range(nc + 1, (1 << w) - 1);
				if (code == tld_pkg::CLEAR_CODE || code == tld_pkg::END_CODE)
					code = (1 << w) - 1;
				k = ncodes;
			end else begin
				if (r < 55 || literal_heavy && r < 90 || nc == tld_pkg::FIRST_FREE)
					code = $urandom_range(255);
				else if (pv && r < 68) code = nc;
				else code = $urandom_range(tld_pkg::FIRST_FREE, nc - 1);
				if (code >= nc && !pv) code = $urandom_range(255);
				if (pv && nc < tld_pkg::DICT_ENTRIES) begin
					nc++;
					if (nc == (1 << w) - 1 && w < tld_pkg::MAX_CODE_BITS) w++;
				end
				pv = 1;
			end
			acc = (acc << w) | code;
			nb += w;
			while (nb >= 8) begin
				bytes = {bytes, 8'(acc >> (nb - 8))};
				nb -= 8;
			end
		end
		if ($urandom_range(1)) begin
			acc = (acc << w) | tld_pkg::END_CODE;
			nb += w;
			end_code = 1;
		end
		while (nb > 0) begin
			if (nb >= 8) begin
				bytes = {bytes, 8'(acc >> (nb - 8))};
				nb -= 8;
			end else begin
				bytes = {bytes, 8'(acc << (8 - nb))};
				nb = 0;
			end
		end
	endtask

	task automatic run_stream(input int ncodes, input bit literal_heavy);
		logic [7:0] bytes [$];
		bit         end_code;
		result_t    r;
		make_stream(ncodes, literal_heavy, bytes, end_code);
		put(tld_pkg::CMD_RESTART, '0, r);
		foreach (bytes[i]) begin
			if ($urandom_range(3) == 0) put(tld_pkg::CMD_PULL, '0, r);
			// a refused byte means the bit buffer is full: pull, then retry
			do begin
				put(tld_pkg::CMD_PUSH, bytes[i], r);
				if (!r.pa) put(tld_pkg::CMD_PULL, '0, r);
			end while (!r.pa);
		end
		if (!end_code || $urandom_range(1)) put(tld_pkg::CMD_END, '0, r);
		do put(tld_pkg::CMD_PULL, '0, r); while (r.ov);
	endtask

	// ---------------------------------------------------------------
	// Directed table
	// ---------------------------------------------------------------
	localparam int N_ROWS = 20;
	row_t dir_rows [N_ROWS] = '{
		'{tld_pkg::CMD_PULL,    8'h00, 1'b1,
			'{8'h00, 1'b0, 1'b0, tld_pkg::ST_NEED_IN, 1'b0}},
		'{tld_pkg::CMD_PUSH,    8'h80, 1'b1, '{8'h00, 1'b0, 1'b1, tld_pkg::ST_OK, 1'b0}},
		'{tld_pkg::CMD_PUSH,    8'h00, 1'b1, '{8'h00, 1'b0, 1'b1, tld_pkg::ST_OK, 1'b0}},
		'{tld_pkg::CMD_PUSH,    8'h00, 1'b1, '{8'h00, 1'b0, 1'b1, tld_pkg::ST_OK, 1'b0}},
		'{tld_pkg::CMD_PULL,    8'h00, 1'b0, '0},
		'{tld_pkg::CMD_PUSH,    8'hFF, 1'b0, '0},
		'{tld_pkg::CMD_PUSH,    8'hFF, 1'b0, '0},
		'{tld_pkg::CMD_PUSH,    8'hFF, 1'b0, '0},
		'{tld_pkg::CMD_PULL,    8'h00, 1'b0, '0},
		'{tld_pkg::CMD_PULL,    8'h00, 1'b0, '0},
		'{tld_pkg::CMD_PULL,    8'h00, 1'b0, '0},
		'{tld_pkg::CMD_END,     8'h00, 1'b0, '0},
		'{tld_pkg::CMD_PULL,    8'h00, 1'b0, '0},
		'{tld_pkg::CMD_PUSH,    8'h5A, 1'b0, '0},
		'{tld_pkg::CMD_RESTART, 8'h00, 1'b1, '0},
		// end code right away: finished with nothing emitted
		'{tld_pkg::CMD_PUSH,    8'h80, 1'b1, '{8'h00, 1'b0, 1'b1, tld_pkg::ST_OK, 1'b0}},
		'{tld_pkg::CMD_PUSH,    8'h80, 1'b1, '{8'h00, 1'b0, 1'b1, tld_pkg::ST_OK, 1'b0}},
		'{tld_pkg::CMD_PULL,    8'h00, 1'b1,
			'{8'h00, 1'b0, 1'b0, tld_pkg::ST_FINISHED, 1'b0}},
		'{tld_pkg::CMD_PUSH,    8'h12, 1'b1,
			'{8'h00, 1'b0, 1'b1, tld_pkg::ST_FINISHED, 1'b0}},
		'{tld_pkg::CMD_RESTART, 8'h00, 1'b1, '0}
	};

	// ---------------------------------------------------------------
	// Result checker
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		result_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tdata[7:0], m_tdata[8], m_tdata[9], m_tdata[12:10], m_tlast};
			if (pending_words.size() == 0) begin
				$error("unexpected result word %h", m_tdata);
				fail_cnt++;
			end else begin
				want = pending_words.pop_front();
				if (got.ob !== want.ob) begin
					$error("out_byte: expected %h, got %h", want.ob, got.ob); fail_cnt++;
				end
				if (got.ov !== want.ov) begin
					$error("out_valid: expected %b, got %b", want.ov, got.ov); fail_cnt++;
				end
				if (got.pa !== want.pa) begin
					$error("push_accepted: expected %b, got %b", want.pa, got.pa); fail_cnt++;
				end
				if (got.st !== want.st) begin
					$error("status: expected %0d, got %0d", want.st, got.st); fail_cnt++;
				end
				if (got.lst !== want.lst) begin
					$error("last: expected %b, got %b", want.lst, got.lst); fail_cnt++;
				end
			end
		end
	end

	// receiver: random stalls, mostly short and a few long, quiet stretches,
	// and a long hold-off on request
	always @(posedge clk) begin
		if (hold_sink) m_tready <= 1'b0;
		else if (quiet) m_tready <= 1'b1;
		else if (sink_gap > 0) begin
			m_tready <= 1'b0;
			sink_gap--;
		end else if ($urandom_range(99) < 70) m_tready <= 1'b1;
		else begin
			m_tready <= 1'b0;
			sink_gap = ($urandom_range(99) < 92) ? $urandom_range(2) : $urandom_range(10, 40);
		end
	end

	// long hold-off: the sender keeps offering, so the block fills and stalls
	initial begin
		wait (words_sent > 200);
		@(posedge clk);
		hold_sink = 1'b1;
		repeat (400) @(posedge clk);
		hold_sink = 1'b0;
	end

	// ---------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------
	initial begin
		result_t r;
		int      ph;
		len_limit = '0;
		clear_decoder();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) send(dir_rows[i].cmd, dir_rows[i].data, dir_rows[i].fixed,
				dir_rows[i].want, r);
		drain();

		// limit set to what was already emitted: next pull finishes
		reg_write(24'd0);
		run_stream(12, 1'b0);
		put(tld_pkg::CMD_RESTART, '0, r);
		put(tld_pkg::CMD_PUSH, 8'h00, r);
		put(tld_pkg::CMD_PUSH, 8'h80, r);
		put(tld_pkg::CMD_PULL, '0, r);
		drain();
		reg_write(24'd1);
		put(tld_pkg::CMD_PULL, '0, r);
		drain();

		ph = 0;
		while (words_sent < 1100) begin
			case (ph % 5)
				0: reg_write(24'd0);
				1: reg_write(24'hFFFFFF);
				2: reg_write(24'd1);
				default: reg_write(24'($urandom_range(2, 40)));
			endcase
			quiet = (ph % 7 == 3);
			if (ph == 0) run_stream(300, 1'b1);   // long enough to widen the codes
			else if (ph % 6 == 5) begin
				// noise: any command, any byte
				repeat (30) put(2'($urandom_range(3)), 8'($urandom_range(255)), r);
				put(tld_pkg::CMD_RESTART, '0, r);
			end else run_stream($urandom_range(4, 20), 1'b0);
			drain();
			ph++;
		end
		quiet = 1'b0;

		wait (pending_words.size() == 0);
		repeat (50) @(posedge clk);
		if (fail_cnt == 0 && pending_words.size() == 0)
			$display("tiff_lzw_decoder test passed");
		else
			$display("tiff_lzw_decoder test failed");
		$finish;
	end

	initial begin
		#40ms;
		$display("tiff_lzw_decoder test failed");
		$finish;
	end

endmodule

// ===== tiff_lzw_decoder.f =====
rtl/tld_pkg.sv
rtl/tld_codeunit.sv
rtl/tld_dict.sv
rtl/tld_stack.sv
rtl/tiff_lzw_decoder.sv
tb/tb_tiff_lzw_decoder.sv
